@@ hw/rtl/rcwct_pkg.sv @@
package rcwct_pkg;

    // Field widths
    localparam int ROW_W      = 6;
    localparam int COL_W      = 10;
    localparam int TEX_W      = 2;
    localparam int COLOR_W    = 24;
    localparam int TEXEL_W    = 10;
    localparam int DIST_W     = 24;
    localparam int FRAC_W     = 16;
    localparam int TWIDTH_W   = 11;
    localparam int LG_W       = 4;
    localparam int LINE_W     = 16;
    localparam int FIX_W      = 32;

    // Largest texture height exponent honoured
    localparam logic [LG_W-1:0] LG_MAX = 4'd10;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [TWIDTH_W-1:0] TEXTURE_WIDTH_RST  = 11'd64;
    localparam logic [LG_W-1:0]     TEXTURE_LOG2_RST   = 4'd6;
    localparam logic [COLOR_W-1:0]  CEILING_COLOR_RST  = 24'h87CEEB;
    localparam logic [COLOR_W-1:0]  FLOOR_COLOR_RST    = 24'h228B22;

    // Shared divider: numerator covers 2^26, denominator covers the distance
    localparam int DIV_NUM_W  = 27;
    localparam int DIV_DEN_W  = 24;

    // Column queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TEXTURE_WIDTH       = 2'd0,
        REG_TEXTURE_HEIGHT_LOG2 = 2'd1,
        REG_CEILING_COLOR       = 2'd2,
        REG_FLOOR_COLOR         = 2'd3
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PK_CEILING = 2'd0,
        PK_WALL    = 2'd1,
        PK_FLOOR   = 2'd2
    } t_pixel_kind;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_DIV_LINE,
        FS_DIV_STEP,
        FS_MUL,
        FS_PUSH
    } t_front_state;

    typedef struct packed {
        logic [TWIDTH_W-1:0] texture_width;
        logic [LG_W-1:0]     texture_height_log2;
        logic [COLOR_W-1:0]  ceiling_color;
        logic [COLOR_W-1:0]  floor_color;
    } t_rcwct_cfg;

    typedef struct packed {
        logic [DIST_W-1:0] wall_distance;
        logic [FRAC_W-1:0] hit_fraction;
        logic              hit_side;
        logic              ray_x_positive;
        logic              ray_y_negative;
        logic [TEX_W-1:0]  texture_number;
        logic [COL_W-1:0]  column;
    } t_rcwct_in;

    typedef struct packed {
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column_out;
        t_pixel_kind        pixel_kind;
        logic [COLOR_W-1:0] color;
        logic [TEXEL_W-1:0] texel_x;
        logic [TEXEL_W-1:0] texel_y;
        logic [TEX_W-1:0]   texture_out;
        logic               last;
    } t_rcwct_out;

    // One classified column waiting for the row sweep
    typedef struct packed {
        logic [ROW_W-1:0]   start_row;
        logic [ROW_W-1:0]   end_row;
        logic [TEXEL_W-1:0] texel_x;
        logic [FIX_W-1:0]   step;
        logic [FIX_W-1:0]   pos;
        logic [TEX_W-1:0]   texture;
        logic [COL_W-1:0]   column;
    } t_rcwct_col;

    function automatic logic [LG_W-1:0] clamp_log2(input logic [LG_W-1:0] lg);
        return (lg > LG_MAX) ? LG_MAX : lg;
    endfunction

endpackage

@@ hw/rtl/rcwct_div.sv @@
module rcwct_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [rcwct_pkg::DIV_NUM_W-1:0]    i_num,
    input  logic [rcwct_pkg::DIV_DEN_W-1:0]    i_den,
    output logic                               o_done,
    output logic [rcwct_pkg::DIV_NUM_W-1:0]    o_quot
);
    import rcwct_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CNT_W-1:0]     r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   w_shift;
    logic [DIV_DEN_W:0]   w_diff;
    logic                 w_fits;

    // Trial subtract of one restoring step
    assign w_shift = {r_rem, r_quo[DIV_NUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};
    assign w_fits  = !w_diff[DIV_DEN_W];

    // Step count and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Shift one quotient bit in per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= w_fits ? w_diff[DIV_DEN_W-1:0] : w_shift[DIV_DEN_W-1:0];
            r_quo <= {r_quo[DIV_NUM_W-2:0], w_fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

@@ hw/rtl/rcwct_front.sv @@
module rcwct_front #(
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_accept,
    input  rcwct_pkg::t_rcwct_in    i_item,
    input  rcwct_pkg::t_rcwct_cfg   i_cfg,
    input  logic                    i_full,
    output logic                    o_busy,
    output logic                    o_push,
    output rcwct_pkg::t_rcwct_col   o_entry
);
    import rcwct_pkg::*;

    localparam logic [DIV_NUM_W-1:0] LINE_NUM  = DIV_NUM_W'(SCREEN_HEIGHT) << 16;
    localparam logic [LINE_W-2:0]    HALF      = (LINE_W-1)'(SCREEN_HEIGHT / 2);
    localparam logic [LINE_W-1:0]    LAST_WIDE = LINE_W'(SCREEN_HEIGHT - 1);
    localparam logic [ROW_W-1:0]     LAST_ROW  = ROW_W'(SCREEN_HEIGHT - 1);
    localparam int                   TXP_W     = FRAC_W + TWIDTH_W;
    localparam int                   POSP_W    = (LINE_W - 1) + FIX_W;

    t_front_state           r_state;
    t_front_state           n_state;

    t_rcwct_in              r_in;
    logic [TXP_W-1:0]       r_tx_prod;
    logic [LINE_W-1:0]      r_line;
    logic [FIX_W-1:0]       r_step;
    logic [FIX_W-1:0]       r_pos;
    logic [ROW_W-1:0]       r_start;
    logic [ROW_W-1:0]       r_end;
    logic [TEXEL_W-1:0]     r_tx;

    logic                   w_div_start;
    logic [DIV_NUM_W-1:0]   w_div_num;
    logic [DIV_DEN_W-1:0]   w_div_den;
    logic                   w_div_done;
    logic [DIV_NUM_W-1:0]   w_quot;

    logic [LINE_W-1:0]      w_line_sat;
    logic [LG_W-1:0]        w_lg;
    logic [4:0]             w_shamt;
    logic [DIV_NUM_W-1:0]   w_step_num;

    logic [LINE_W-2:0]      w_lhalf;
    logic                   w_wide;
    logic [LINE_W-2:0]      w_offset;
    logic [LINE_W-1:0]      w_end_sum;
    logic [POSP_W-1:0]      w_pos_prod;
    logic [TWIDTH_W-1:0]    w_tx_raw;
    logic [TWIDTH_W-1:0]    w_tx_mir;
    logic                   w_mirror;

    rcwct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // Saturate the line height and form the step numerator
    assign w_line_sat = (|w_quot[DIV_NUM_W-1:LINE_W]) ? {LINE_W{1'b1}} : w_quot[LINE_W-1:0];
    assign w_lg       = clamp_log2(i_cfg.texture_height_log2);
    assign w_shamt    = {1'b0, w_lg} + 5'd16;
    assign w_step_num = DIV_NUM_W'(1) << w_shamt;

    // Clamp rows and find the texture offset of the top visible row
    assign w_lhalf    = r_line[LINE_W-1:1];
    assign w_wide     = (w_lhalf >= HALF);
    assign w_offset   = w_wide ? (w_lhalf - HALF) : '0;
    assign w_end_sum  = {1'b0, w_lhalf} + {1'b0, HALF};
    assign w_pos_prod = w_offset * r_step;

    // Texture column, mirrored for walls seen from the far side
    assign w_tx_raw = r_tx_prod[TXP_W-1:FRAC_W];
    assign w_tx_mir = i_cfg.texture_width - w_tx_raw - TWIDTH_W'(1);
    assign w_mirror = (!r_in.hit_side && r_in.ray_x_positive)
                   || (r_in.hit_side && r_in.ray_y_negative);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequence one or two divisions, the offset multiply and the queue push
    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        w_div_num   = LINE_NUM;
        w_div_den   = i_item.wall_distance;
        unique case (r_state)
            FS_IDLE: begin
                if (i_accept) begin
                    n_state     = FS_DIV_LINE;
                    w_div_start = 1'b1;
                end
            end
            FS_DIV_LINE: begin
                if (w_div_done) begin
                    if (w_line_sat != '0) begin
                        n_state     = FS_DIV_STEP;
                        w_div_start = 1'b1;
                        w_div_num   = w_step_num;
                        w_div_den   = DIV_DEN_W'(w_line_sat);
                    end else begin
                        n_state = FS_MUL;
                    end
                end
            end
            FS_DIV_STEP: begin
                if (w_div_done) begin
                    n_state = FS_MUL;
                end
            end
            FS_MUL: begin
                n_state = FS_PUSH;
            end
            FS_PUSH: begin
                if (!i_full) begin
                    n_state = FS_IDLE;
                end
            end
            default: begin
                n_state = FS_IDLE;
            end
        endcase
    end

    // Column datapath
    always_ff @(posedge i_clk) begin
        if (r_state == FS_IDLE && i_accept) begin
            r_in <= i_item;
        end
        if (r_state == FS_DIV_LINE) begin
            r_tx_prod <= r_in.hit_fraction * i_cfg.texture_width;
            if (w_div_done) begin
                r_line <= w_line_sat;
                r_step <= '0;
            end
        end
        if (r_state == FS_DIV_STEP && w_div_done) begin
            r_step <= FIX_W'(w_quot);
        end
        if (r_state == FS_MUL) begin
            r_pos   <= w_pos_prod[FIX_W-1:0];
            r_start <= w_wide ? '0 : ROW_W'(HALF - w_lhalf);
            r_end   <= (w_end_sum > LAST_WIDE) ? LAST_ROW : w_end_sum[ROW_W-1:0];
            r_tx    <= w_mirror ? w_tx_mir[TEXEL_W-1:0] : w_tx_raw[TEXEL_W-1:0];
        end
    end

    assign o_busy = (r_state != FS_IDLE);
    assign o_push = (r_state == FS_PUSH) && !i_full;

    always_comb begin
        o_entry.start_row = r_start;
        o_entry.end_row   = r_end;
        o_entry.texel_x   = r_tx;
        o_entry.step      = r_step;
        o_entry.pos       = r_pos;
        o_entry.texture   = r_in.texture_number;
        o_entry.column    = r_in.column;
    end

endmodule

@@ hw/rtl/rcwct_queue.sv @@
module rcwct_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  rcwct_pkg::t_rcwct_col   i_data,
    input  logic                    i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output rcwct_pkg::t_rcwct_col   o_data
);
    import rcwct_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_rcwct_col         r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    // Hold the column entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_slot[r_rd_ptr];

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("column queue over capacity");

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("column pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("column popped from an empty queue");

endmodule

@@ hw/rtl/rcwct_back.sv @@
module rcwct_back #(
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    input  rcwct_pkg::t_rcwct_col   i_q_data,
    input  rcwct_pkg::t_rcwct_cfg   i_cfg,
    output logic                    o_pop,
    output logic                    o_result_valid,
    output rcwct_pkg::t_rcwct_out   o_result
);
    import rcwct_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);

    logic                 r_active;
    logic [ROW_W-1:0]     r_row;
    t_rcwct_col           r_col;
    logic [FIX_W-1:0]     r_pos;
    logic                 r_valid;
    t_rcwct_out           r_out;

    t_rcwct_out           n_out;
    logic [LG_W-1:0]      w_lg;
    logic [TEXEL_W:0]     w_hmask_full;
    logic [TEXEL_W-1:0]   w_hmask;
    logic                 w_last;
    logic                 w_is_wall;

    assign w_lg         = clamp_log2(i_cfg.texture_height_log2);
    assign w_hmask_full = ((TEXEL_W+1)'(1) << w_lg) - (TEXEL_W+1)'(1);
    assign w_hmask      = w_hmask_full[TEXEL_W-1:0];
    assign w_last       = (r_row == LAST_ROW);
    assign w_is_wall    = (r_row >= r_col.start_row) && (r_row <= r_col.end_row);

    // Take the next column when idle or on the bottom row
    assign o_pop = !i_q_empty && (!r_active || w_last);

    // Classify the current row
    always_comb begin
        n_out.row         = r_row;
        n_out.column_out  = r_col.column;
        n_out.texture_out = r_col.texture;
        n_out.last        = w_last;
        n_out.texel_x     = '0;
        n_out.texel_y     = '0;
        if (r_row < r_col.start_row) begin
            n_out.pixel_kind = PK_CEILING;
            n_out.color      = i_cfg.ceiling_color;
        end else if (w_is_wall) begin
            n_out.pixel_kind = PK_WALL;
            n_out.color      = '0;
            n_out.texel_x    = r_col.texel_x;
            n_out.texel_y    = r_pos[16 +: TEXEL_W] & w_hmask;
        end else begin
            n_out.pixel_kind = PK_FLOOR;
            n_out.color      = i_cfg.floor_color;
        end
    end

    // Sweep control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
            end else if (r_active && w_last) begin
                r_active <= 1'b0;
            end
        end
    end

    // Row counter, texture position and output register
    always_ff @(posedge i_clk) begin
        if (r_active) begin
            r_out <= n_out;
        end
        if (o_pop) begin
            r_col <= i_q_data;
            r_row <= '0;
            r_pos <= i_q_data.pos;
        end else if (r_active) begin
            r_row <= r_row + ROW_W'(1);
            if (w_is_wall) begin
                r_pos <= r_pos + r_col.step;
            end
        end
    end

    assign o_result_valid = r_valid;
    assign o_result       = r_out;

    a_rows_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_out.last |=> r_valid && (r_out.row == $past(r_out.row) + ROW_W'(1)))
        else $error("row sweep broke off inside a column");

    a_flat_no_texel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_out.pixel_kind != PK_WALL) |-> (r_out.texel_x == '0) && (r_out.texel_y == '0))
        else $error("texel coordinates on a ceiling or floor row");

    a_floor_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && (r_out.pixel_kind == PK_FLOOR) && !r_out.last
        |=> r_out.pixel_kind == PK_FLOOR)
        else $error("floor row followed by another kind in one column");

endmodule

@@ hw/rtl/raycast_wall_column_texturer.sv @@
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+---------------------------
// item      | in        | start high, busy low      | i_item (t_rcwct_in)
// result    | out       | o_result_valid, 1 cycle   | o_result (t_rcwct_out)
// config    | in        | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// One result per clock while a column is swept; the row sweep of the back end gives
// SCREEN_HEIGHT rows per column. The front end holds busy after a transaction for two
// passes through the shared bit-serial divider, a multiply state and a push state
// (one divider pass when the wall height is zero), and stays in the push state while
// the queue is full. It takes a new column only after the last one is pushed, while
// the back end may still sweep earlier columns; the slower side sets the rate. Reset
// restores the register defaults and empties the queue. The receiver cannot stall
// results.
module raycast_wall_column_texturer #(
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  rcwct_pkg::t_rcwct_in                 i_item,
    output logic                                 o_result_valid,
    output rcwct_pkg::t_rcwct_out                o_result,
    input  logic                                 i_cfg_we,
    input  logic [rcwct_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rcwct_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import rcwct_pkg::*;

    t_rcwct_cfg   r_cfg;

    logic         w_front_busy;
    logic         w_accept;
    logic         w_push;
    logic         w_pop;
    logic         w_full;
    logic         w_empty;
    t_rcwct_col   w_push_data;
    t_rcwct_col   w_pop_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.texture_width       <= TEXTURE_WIDTH_RST;
            r_cfg.texture_height_log2 <= TEXTURE_LOG2_RST;
            r_cfg.ceiling_color       <= CEILING_COLOR_RST;
            r_cfg.floor_color         <= FLOOR_COLOR_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_index))
                REG_TEXTURE_WIDTH:       r_cfg.texture_width       <= i_cfg_data[TWIDTH_W-1:0];
                REG_TEXTURE_HEIGHT_LOG2: r_cfg.texture_height_log2 <= i_cfg_data[LG_W-1:0];
                REG_CEILING_COLOR:       r_cfg.ceiling_color       <= i_cfg_data[COLOR_W-1:0];
                REG_FLOOR_COLOR:         r_cfg.floor_color         <= i_cfg_data[COLOR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign busy     = w_front_busy;
    assign w_accept = start && !w_front_busy;

    rcwct_front #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_full   (w_full),
        .o_busy   (w_front_busy),
        .o_push   (w_push),
        .o_entry  (w_push_data)
    );

    rcwct_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_pop_data)
    );

    rcwct_back #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_empty),
        .i_q_data       (w_pop_data),
        .i_cfg          (r_cfg),
        .o_pop          (w_pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import rcwct_pkg::*;

    localparam int SCREEN_H = 64;
    localparam int HALF     = SCREEN_H / 2;

    // Predicts the pixels of each accepted column and checks them in order
    class column_pixel_board;
        t_rcwct_out     pending_pixels[$];
        logic [10:0]    tex_width;
        logic [3:0]     tex_lg;
        logic [23:0]    ceil_rgb;
        logic [23:0]    floor_rgb;
        int unsigned    columns_noted;
        int unsigned    pixels_checked;
        int unsigned    errors;

        function new();
            tex_width      = 11'd64;
            tex_lg         = 4'd6;
            ceil_rgb       = 24'h87CEEB;
            floor_rgb      = 24'h228B22;
            columns_noted  = 0;
            pixels_checked = 0;
            errors         = 0;
        endfunction

        function void set_register(t_cfg_reg idx, logic [23:0] data);
            case (idx)
                REG_TEXTURE_WIDTH:       tex_width = data[10:0];
                REG_TEXTURE_HEIGHT_LOG2: tex_lg    = data[3:0];
                REG_CEILING_COLOR:       ceil_rgb  = data;
                REG_FLOOR_COLOR:         floor_rgb = data;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_pixels.size();
        endfunction

        // Work out the whole row sweep of one column
        function void note_column(t_rcwct_in it);
            bit [31:0]   line;
            bit [31:0]   lhalf;
            bit [31:0]   first_row;
            bit [31:0]   last_row;
            bit [31:0]   tx;
            bit [31:0]   step;
            bit [31:0]   pos;
            bit [31:0]   hmask;
            bit [63:0]   wide;
            bit [3:0]    lg;
            int unsigned y;
            t_rcwct_out  px;

            lg    = (tex_lg > LG_MAX) ? LG_MAX : tex_lg;
            hmask = (32'd1 << lg) - 32'd1;

            // Wall height, saturated; a zero distance saturates too
            if (it.wall_distance == 0) begin
                line = 32'd65535;
            end else begin
                line = (32'(SCREEN_H) << 16) / 32'(it.wall_distance);
                if (line > 32'd65535) begin
                    line = 32'd65535;
                end
            end
            lhalf     = line >> 1;
            first_row = (lhalf >= HALF) ? 32'd0 : HALF - lhalf;
            last_row  = HALF + lhalf;
            if (last_row > SCREEN_H - 1) begin
                last_row = SCREEN_H - 1;
            end

            // Texture column, mirrored on the far-facing sides
            tx = (32'(it.hit_fraction) * 32'(tex_width)) >> 16;
            if ((!it.hit_side && it.ray_x_positive) || (it.hit_side && it.ray_y_negative)) begin
                tx = 32'(tex_width) - tx - 32'd1;
            end

            if (line == 0) begin
                step = 32'd0;
                pos  = 32'd0;
            end else begin
                wide = (64'd1 << (lg + 16)) / 64'(line);
                step = wide[31:0];
                pos  = (first_row + lhalf - HALF) * step;
            end

            for (y = 0; y < SCREEN_H; y++) begin
                px             = '0;
                px.row         = y[5:0];
                px.column_out  = it.column;
                px.texture_out = it.texture_number;
                px.last        = (y == SCREEN_H - 1);
                if (y < first_row) begin
                    px.pixel_kind = PK_CEILING;
                    px.color      = ceil_rgb;
                end else if (y <= last_row) begin
                    px.pixel_kind = PK_WALL;
                    px.texel_x    = tx[9:0];
                    px.texel_y    = 10'((pos >> 16) & hmask);
                    pos           = pos + step;
                end else begin
                    px.pixel_kind = PK_FLOOR;
                    px.color      = floor_rgb;
                end
                pending_pixels.push_back(px);
            end
            columns_noted++;
        endfunction

        function bit field_differs(string name, t_rcwct_out want, logic [31:0] exp_v,
                                   logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t: column %0d row %0d %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, want.column_out, want.row, name, exp_v, act_v);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Compare one pixel with the oldest prediction
        function void check_pixel(t_rcwct_out got);
            t_rcwct_out want;
            bit         bad;

            if (pending_pixels.size() == 0) begin
                $display("%0t: unexpected pixel: expected none, actual 0x%0h", $time, got);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            bad  = 1'b0;
            bad |= field_differs("row", want, want.row, got.row);
            bad |= field_differs("column_out", want, want.column_out, got.column_out);
            bad |= field_differs("pixel_kind", want, want.pixel_kind, got.pixel_kind);
            bad |= field_differs("color", want, want.color, got.color);
            bad |= field_differs("texel_x", want, want.texel_x, got.texel_x);
            bad |= field_differs("texel_y", want, want.texel_y, got.texel_y);
            bad |= field_differs("texture_out", want, want.texture_out, got.texture_out);
            bad |= field_differs("last", want, want.last, got.last);
            if (bad) begin
                errors++;
            end
            pixels_checked++;
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_rcwct_in             i_item      = '0;
    logic                  o_result_valid;
    t_rcwct_out            o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    column_pixel_board board;
    t_rcwct_in         directed_q[$];
    int unsigned       settings_used = 0;

    raycast_wall_column_texturer #(
        .SCREEN_HEIGHT(SCREEN_H)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Check every pixel the block presents
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid !== 1'b0) begin
            board.check_pixel(o_result);
        end
    end

    // Hold the column until the block takes it; start stays high for the caller
    task automatic send_column(input t_rcwct_in it);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_column(it);
    endtask

    // Drop start and put noise on the item bus for a while
    task automatic pause(input int unsigned cycles);
        logic [63:0] junk;
        junk   = {$urandom, $urandom};
        start  <= 1'b0;
        i_item <= junk[$bits(t_rcwct_in)-1:0];
        repeat (cycles) @(posedge i_clk);
    endtask

    // Wait for every predicted pixel, then some more for stray ones
    task automatic drain();
        start <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (130) @(posedge i_clk);
    endtask

    // Write all four registers on consecutive cycles; noisy fills unused data bits
    task automatic program_registers(input logic [10:0] width, input logic [3:0] lg,
                                     input logic [23:0] ceil_rgb, input logic [23:0] floor_rgb,
                                     input bit noisy);
        logic [23:0] vals [4];
        logic [23:0] fill;
        t_cfg_reg    idx;
        int          k;
        fill    = noisy ? 24'($urandom) : 24'd0;
        vals[0] = {fill[23:11], width};
        vals[1] = {fill[23:4], lg};
        vals[2] = ceil_rgb;
        vals[3] = floor_rgb;
        for (k = 0; k < 4; k++) begin
            idx = t_cfg_reg'(k);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= vals[k];
            @(posedge i_clk);
            board.set_register(idx, vals[k]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic t_rcwct_in make_column(logic [23:0] distance, logic [15:0] frac,
                                              logic side, logic xpos, logic yneg,
                                              logic [1:0] tex, logic [9:0] col);
        t_rcwct_in it;
        it.wall_distance  = distance;
        it.hit_fraction   = frac;
        it.hit_side       = side;
        it.ray_x_positive = xpos;
        it.ray_y_negative = yneg;
        it.texture_number = tex;
        it.column         = col;
        return it;
    endfunction

    // Mostly wall heights that land on screen, some saturated, some vanishing
    function automatic t_rcwct_in random_column();
        t_rcwct_in   it;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0:       it.wall_distance = 24'($urandom);
            1:       it.wall_distance = 24'($urandom_range(0, 64));
            2:       it.wall_distance = 24'($urandom_range(24'h200000, 24'hFFFFFF));
            default: it.wall_distance = 24'($urandom_range(24'h004000, 24'h100000));
        endcase
        it.hit_fraction   = 16'($urandom);
        it.hit_side       = 1'($urandom);
        it.ray_x_positive = 1'($urandom);
        it.ray_y_negative = 1'($urandom);
        it.texture_number = 2'($urandom);
        it.column         = 10'($urandom);
        return it;
    endfunction

    // Bursts of back-to-back columns with random gaps, sometimes none, between them
    task automatic run_random_phase(input int unsigned n_items);
        int unsigned sent;
        int unsigned burst;
        int unsigned pick;
        sent = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 8);
            while (burst != 0 && sent < n_items) begin
                send_column(random_column());
                sent++;
                burst--;
            end
            pick = $urandom_range(0, 9);
            if (pick >= 3) begin
                pause(pick >= 8 ? $urandom_range(21, 140) : $urandom_range(1, 20));
            end
        end
    endtask

    initial begin
        int p;
        board = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed columns under the reset settings
        directed_q.push_back(make_column(24'h000000, 16'h0000, 0, 0, 0, 0, 0));
        directed_q.push_back(make_column(24'h000001, 16'hFFFF, 0, 1, 0, 1, 1023));
        directed_q.push_back(make_column(24'h00003F, 16'h8000, 0, 0, 1, 2, 5));
        directed_q.push_back(make_column(24'h000040, 16'h0001, 1, 0, 0, 3, 6));
        directed_q.push_back(make_column(24'h000041, 16'h7FFF, 1, 0, 1, 0, 7));
        directed_q.push_back(make_column(24'h010000, 16'h4000, 1, 1, 0, 1, 100));
        directed_q.push_back(make_column(24'h020000, 16'hC000, 1, 1, 1, 2, 200));
        directed_q.push_back(make_column(24'h008000, 16'hFFFF, 0, 1, 1, 3, 300));
        directed_q.push_back(make_column(24'h400000, 16'h1234, 0, 0, 0, 0, 400));
        directed_q.push_back(make_column(24'h400001, 16'h5678, 0, 1, 0, 1, 500));
        directed_q.push_back(make_column(24'hFFFFFF, 16'hFFFF, 1, 1, 1, 3, 1023));
        directed_q.push_back(make_column(24'h200000, 16'h0000, 1, 0, 1, 2, 600));
        directed_q.push_back(make_column(24'h155555, 16'hAAAA, 0, 1, 1, 1, 601));
        directed_q.push_back(make_column(24'h0F0000, 16'h5555, 1, 1, 0, 0, 602));
        directed_q.push_back(make_column(24'h00C000, 16'h0100, 0, 0, 1, 3, 603));
        directed_q.push_back(make_column(24'h00FFFF, 16'hFF00, 1, 0, 0, 2, 604));
        directed_q.push_back(make_column(24'h010001, 16'h8001, 0, 1, 0, 1, 605));
        directed_q.push_back(make_column(24'h7FFFFF, 16'h0F0F, 1, 1, 1, 0, 512));
        foreach (directed_q[i]) begin
            send_column(directed_q[i]);
            if ($urandom_range(0, 2) == 0) begin
                pause($urandom_range(1, 70));
            end
        end
        drain();

        // Random phases, each under its own register setting
        for (p = 0; p < 6; p++) begin
            case (p)
                0: program_registers(11'd1, 4'd0, 24'h000000, 24'hFFFFFF, 1'b0);
                1: program_registers(11'd1024, 4'd10, 24'hFFFFFF, 24'h000000, 1'b1);
                2: program_registers(11'd0, 4'd15, 24'($urandom), 24'($urandom), 1'b1);
                3: program_registers(11'd2047, 4'($urandom_range(11, 14)), 24'($urandom),
                                     24'($urandom), 1'b1);
                default: program_registers(11'($urandom_range(1, 1024)),
                                           4'($urandom_range(0, 10)), 24'($urandom),
                                           24'($urandom), 1'($urandom));
            endcase
            run_random_phase(27);
            drain();
        end

        $display("Summary: %0d columns over %0d register settings, %0d pixels compared, %0d bad",
                 board.columns_noted, settings_used + 1, board.pixels_checked, board.errors);
        if (board.errors == 0) begin
            $display("** raycast_wall_column_texturer: PASSED **");
        end else begin
            $display("** raycast_wall_column_texturer: FAILED **");
        end
        $finish;
    end

    // Give up if the block stalls
    initial begin
        #8_000_000;
        $display("Timeout with %0d pixels still expected", board.pending());
        $display("** raycast_wall_column_texturer: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/rcwct_pkg.sv
hw/rtl/rcwct_div.sv
hw/rtl/rcwct_front.sv
hw/rtl/rcwct_queue.sv
hw/rtl/rcwct_back.sv
hw/rtl/raycast_wall_column_texturer.sv
tb/tb_top.sv
